[hw/rtl/prmv_pkg.sv]
// Shared constants and types for the per-pixel running mean / variance core.
// No dependencies.
`default_nettype none
package prmv_pkg;
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int COUNT_BITS  = 24;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SAMPLE_W    = 32;
  localparam int SPREAD_W    = 63;
  localparam int DIVD_W      = 63;
  localparam int STEP_W      = 6;
  // ceil(2^19 / 3): exact divide by three for 18-bit digits
  localparam logic [17:0] DIV3_RECIP = 18'd174763;

  typedef struct packed {
    logic [COUNT_BITS-1:0]          cnt;
    logic [SPREAD_W-1:0]            spread;
    logic [2:0][SAMPLE_W-1:0]       mean;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                  start;
    logic [DIVD_W-1:0]     dividend;
    logic [COUNT_BITS-1:0] divisor;
    logic [STEP_W-1:0]     steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

[hw/rtl/prmv_ram.sv]
// Generic single-port synchronous RAM; read data is registered, valid the cycle after the read.
// No dependencies.
`default_nettype none
module prmv_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end
endmodule
`default_nettype wire

[hw/rtl/prmv_div.sv]
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
// Depends on prmv_pkg. Dividend is supplied left-aligned; steps gives its width.
`default_nettype none
module prmv_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire prmv_pkg::div_req_t req_i,
  output prmv_pkg::div_rsp_t      rsp_o
);
  import prmv_pkg::*;

  logic                  busy_q, done_q;
  logic [COUNT_BITS-1:0] rem_q, div_q;
  logic [DIVD_W-1:0]     quo_q;
  logic [STEP_W-1:0]     left_q;
  logic [COUNT_BITS:0]   trial, diff;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign ge    = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      left_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        left_q <= req_i.steps;
      end else if (busy_q) begin
        left_q <= left_q - 1'b1;
        if (left_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule
`default_nettype wire

[hw/rtl/pixel_running_mean_variance_core.sv]
// Per-pixel running mean and variance (Welford) over RGB Q16.16 samples.
// Depends on prmv_pkg, prmv_ram and prmv_div.
//
// One item is processed at a time. After reset the pixel store is cleared, all
// 65536 entries, one entry per cycle, during which no word is accepted. For an
// accepted sample the single bit-serial divider does three 32-step mean
// divisions and a 63-step variance division, and the divide by three is a
// reciprocal multiply taken 16 bits at a time; a rejected sample does only the
// variance division. A finished result waits in the output register while the
// next word is accepted.
`default_nettype none
module pixel_running_mean_variance_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cfg_we_i,
  input  wire logic [8:0]   cfg_wdata_i,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // pixel_x, pixel_y, sample_red, sample_green, sample_blue
  input  wire logic [111:0] s_axis_tdata,
  // sample_valid
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // mean_red, mean_green, mean_blue, variance_estimate, samples_taken, pad
  output logic [183:0]      m_axis_tdata,
  // accepted
  output logic [0:0]        m_axis_tuser
);
  import prmv_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_MST, ST_MWAIT, ST_MUL,
    ST_TST, ST_TWAIT, ST_SAT, ST_VWAIT, ST_OUT
  } state_e;

  state_e                  st_q;
  logic [8:0]              width_q;
  logic                    clr_busy_q;
  logic [ADDR_W-1:0]       clr_addr_q, addr_q;
  logic                    vld_q, acc_q;
  logic [2:0][SAMPLE_W-1:0] samp_q, mean_q;
  logic [SPREAD_W-1:0]     sp_q, var_q;
  logic [COUNT_BITS-1:0]   cnt_q;
  logic [1:0]              ch_q;
  logic                    neg_q;
  logic [31:0]             ad_q, ar_q;
  logic [65:0]             sum_q;
  logic [63:0]             add_q;
  logic [1:0]              rem3_q, dig_q;
  logic                    out_valid_q, out_acc_q;
  logic [183:0]            out_data_q;

  logic                    s_acc, ram_we, ram_re;
  logic [ADDR_W-1:0]       ram_addr;
  entry_t                  ram_rdata, ram_wdata;
  div_req_t                dreq;
  div_rsp_t                drsp;
  logic [16:0]             lin_addr;
  logic [32:0]             d_w, nm_w, r_w;
  logic [31:0]             ad_w, q_w;
  logic [63:0]             sp_sum;
  logic [SPREAD_W-1:0]     sp_w;
  logic [COUNT_BITS-1:0]   vdiv;
  logic                    e_acc;
  logic [17:0]             v3_w, r3_w;
  logic [35:0]             p3_w;
  logic [15:0]             q3_w;

  assign s_axis_tready = (st_q == ST_IDLE) && !clr_busy_q;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign lin_addr      = {9'b0, s_axis_tdata[7:0]} + 17'(s_axis_tdata[15:8]) * 17'(width_q);

  assign d_w  = {samp_q[ch_q][31], samp_q[ch_q]} - {mean_q[ch_q][31], mean_q[ch_q]};
  assign ad_w = d_w[32] ? 32'(-d_w) : d_w[31:0];
  assign q_w  = drsp.quotient[31:0];
  assign nm_w = {mean_q[ch_q][31], mean_q[ch_q]} + (neg_q ? -{1'b0, q_w} : {1'b0, q_w});
  assign r_w  = {samp_q[ch_q][31], samp_q[ch_q]} - nm_w;

  // divide by three, 16 bits per cycle from the top
  assign v3_w = {rem3_q, add_q[63:48]};
  assign p3_w = v3_w * DIV3_RECIP;
  assign q3_w = p3_w[34:19];
  assign r3_w = v3_w - {q3_w, 1'b0} - {2'b00, q3_w};

  assign sp_sum = {1'b0, sp_q} + add_q;
  assign sp_w   = !acc_q ? sp_q : (sp_sum[63] ? {SPREAD_W{1'b1}} : sp_sum[SPREAD_W-1:0]);
  assign vdiv   = (cnt_q > COUNT_BITS'(1)) ? cnt_q - 1'b1 : COUNT_BITS'(1);
  assign e_acc  = vld_q && (ram_rdata.cnt != {COUNT_BITS{1'b1}});

  always_comb begin
    dreq = '0;
    case (st_q)
      ST_MST: begin
        dreq.start    = 1'b1;
        dreq.dividend = {ad_w, 31'b0};
        dreq.divisor  = cnt_q;
        dreq.steps    = STEP_W'(32);
      end
      ST_SAT: begin
        dreq.start    = 1'b1;
        dreq.dividend = sp_w;
        dreq.divisor  = vdiv;
        dreq.steps    = STEP_W'(63);
      end
      default: dreq = '0;
    endcase
  end

  assign ram_we   = clr_busy_q || (st_q == ST_VWAIT && drsp.done && acc_q);
  assign ram_re   = (st_q == ST_RD);
  assign ram_addr = clr_busy_q ? clr_addr_q : addr_q;
  always_comb begin
    ram_wdata        = '0;
    if (!clr_busy_q) begin
      ram_wdata.cnt    = cnt_q;
      ram_wdata.spread = sp_q;
      ram_wdata.mean   = mean_q;
    end
  end

  prmv_ram #(.DW(ENTRY_W), .AW(ADDR_W)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  prmv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 9'd256;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == {ADDR_W{1'b1}}) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (st_q == ST_OUT && (!out_valid_q || m_axis_tready)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        ST_IDLE:  if (s_acc) st_q <= ST_RD;
        ST_RD:    st_q <= ST_CHK;
        ST_CHK:   st_q <= e_acc ? ST_MST : ST_SAT;
        ST_MST:   st_q <= ST_MWAIT;
        ST_MWAIT: if (drsp.done) st_q <= ST_MUL;
        ST_MUL:   st_q <= (ch_q == 2'd2) ? ST_TST : ST_MST;
        ST_TST:   st_q <= ST_TWAIT;
        ST_TWAIT: if (dig_q == 2'd3) st_q <= ST_SAT;
        ST_SAT:   st_q <= ST_VWAIT;
        ST_VWAIT: if (drsp.done) st_q <= ST_OUT;
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        addr_q <= lin_addr[ADDR_W-1:0];
        vld_q  <= s_axis_tuser[0] && ({1'b0, s_axis_tdata[7:0]} < width_q);
        samp_q <= s_axis_tdata[111:16];
      end
      ST_CHK: begin
        mean_q <= ram_rdata.mean;
        sp_q   <= ram_rdata.spread;
        acc_q  <= e_acc;
        cnt_q  <= e_acc ? ram_rdata.cnt + 1'b1 : ram_rdata.cnt;
        sum_q  <= '0;
        ch_q   <= 2'd0;
      end
      ST_MST: begin
        neg_q <= d_w[32];
        ad_q  <= ad_w;
      end
      ST_MWAIT: begin
        if (drsp.done) begin
          mean_q[ch_q] <= nm_w[31:0];
          ar_q         <= r_w[32] ? 32'(-r_w) : r_w[31:0];
        end
      end
      ST_MUL: begin
        sum_q <= sum_q + 66'(ad_q * ar_q);
        ch_q  <= ch_q + 1'b1;
      end
      ST_TST: begin
        add_q  <= {14'b0, sum_q[65:16]};
        rem3_q <= 2'd0;
        dig_q  <= 2'd0;
      end
      ST_TWAIT: begin
        add_q  <= {add_q[47:0], q3_w};
        rem3_q <= r3_w[1:0];
        dig_q  <= dig_q + 1'b1;
      end
      ST_SAT:   sp_q <= sp_w;
      ST_VWAIT: if (drsp.done) var_q <= drsp.quotient;
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_q <= {1'b0, cnt_q, var_q, mean_q};
          out_acc_q  <= acc_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_acc_q;

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> !clr_busy_q) else $error("word accepted during store clear");
  a_write_only_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && !clr_busy_q) |-> acc_q) else $error("store written for rejected word");
  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> (st_q == ST_MWAIT || st_q == ST_VWAIT))
    else $error("divider finished outside a wait state");
endmodule
`default_nettype wire

[test/testbench.sv]
// Self-checking testbench for pixel_running_mean_variance_core.
// Depends on prmv_pkg and the core RTL. A built-in per-pixel Welford predictor
// checks every output word against the oldest expected statistics.
`timescale 1ns / 100ps
module testbench;
  import prmv_pkg::*;

  typedef struct {
    logic signed [31:0] mean [3];
    logic [62:0]        spread;
    logic [23:0]        cnt;
  } pixel_stats_t;

  typedef struct {
    logic [31:0] mean [3];
    logic [62:0] variance;
    logic [23:0] cnt;
    logic        acc;
  } stats_word_t;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 300;
  localparam logic [62:0] SPREAD_SAT = {63{1'b1}};
  localparam logic [23:0] COUNT_SAT  = {24{1'b1}};

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [8:0]    cfg_wdata_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata = '0;
  logic [0:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [183:0]  m_axis_tdata;
  logic [0:0]    m_axis_tuser;

  pixel_running_mean_variance_core DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pixel_stats_t pixel_mem [int];
  logic [8:0]   width_reg = 9'd256;
  stats_word_t  stats_q [$];
  int           fail_cnt = 0;
  int           idle_cycles = 0;
  int           tx_idle_pct = 32;
  int           rx_idle_pct = 32;
  int           rx_hold = 0;

  // Welford update of the predicted pixel store, returns the expected word
  function automatic stats_word_t welford_update(logic [7:0] px, logic [7:0] py,
                                                 logic [31:0] smp [3], logic vld);
    pixel_stats_t st;
    stats_word_t  w;
    int           addr;
    longint       s, m, d, nm, r, n;
    logic [63:0]  ad, ar, p;
    logic [65:0]  acc_sum;
    logic [62:0]  add, div;
    addr = (int'(px) + int'(py) * int'(width_reg)) % STORE_DEPTH;
    if (pixel_mem.exists(addr)) st = pixel_mem[addr];
    else begin
      st.mean = '{0, 0, 0};
      st.spread = '0;
      st.cnt = '0;
    end
    w.acc = vld && (px < width_reg) && (st.cnt != COUNT_SAT);
    if (w.acc) begin
      n = longint'(st.cnt) + 1;
      acc_sum = '0;
      for (int c = 0; c < 3; c++) begin
        s = longint'(signed'(smp[c]));
        m = longint'(st.mean[c]);
        d = s - m;
        nm = m + d / n;
        r = s - nm;
        ad = (d < 0) ? -d : d;
        ar = (r < 0) ? -r : r;
        p = ad * ar;
        acc_sum = acc_sum + {2'b00, p};
        st.mean[c] = nm[31:0];
      end
      add = 63'((acc_sum >> 16) / 3);
      st.spread = (add > SPREAD_SAT - st.spread) ? SPREAD_SAT : st.spread + add;
      st.cnt = n[23:0];
      pixel_mem[addr] = st;
    end
    div = (st.cnt > 1) ? 63'(st.cnt - 1) : 63'd1;
    for (int c = 0; c < 3; c++) w.mean[c] = st.mean[c];
    w.variance = st.spread / div;
    w.cnt = st.cnt;
    return w;
  endfunction

  task automatic send_word(logic [7:0] px, logic [7:0] py, logic [31:0] r,
                           logic [31:0] g, logic [31:0] b, logic vld);
    logic [31:0] smp [3];
    smp = '{r, g, b};
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {b, g, r, py, px};
    s_axis_tuser  = vld;
    do @(posedge clk_i); while (!s_axis_tready);
    stats_q.push_back(welford_update(px, py, smp, vld));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_width(logic [8:0] w);
    drain();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = w;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    width_reg = w;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(32'h0003_0000);
      3: return -$urandom_range(32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  // receiver: random idling plus a long hold-off whenever rx_hold is set
  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    stats_word_t exp_w;
    stats_word_t act;
    if (m_axis_tvalid && m_axis_tready) begin
      act.mean[0]  = m_axis_tdata[31:0];
      act.mean[1]  = m_axis_tdata[63:32];
      act.mean[2]  = m_axis_tdata[95:64];
      act.variance = m_axis_tdata[158:96];
      act.cnt      = m_axis_tdata[182:159];
      act.acc      = m_axis_tuser[0];
      if (stats_q.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected word, actual %p", $realtime, act);
      end else begin
        exp_w = stats_q.pop_front();
        if (exp_w.mean[0] !== act.mean[0] || exp_w.mean[1] !== act.mean[1] ||
            exp_w.mean[2] !== act.mean[2] || exp_w.variance !== act.variance ||
            exp_w.cnt !== act.cnt || exp_w.acc !== act.acc) begin
          fail_cnt++;
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_w, act);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic test_extremes();
    send_word(8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1);
    send_word(8'd0, 8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_word(8'd0, 8'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b1);
    send_word(8'd255, 8'd255, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000, 1'b1);
    send_word(8'd255, 8'd255, 32'h0, 32'h0, 32'h0, 1'b1);
    send_word(8'd0, 8'd0, 32'h1234_5678, 32'h0, 32'h0, 1'b0);
    send_word(8'd7, 8'd3, 32'h0, 32'h0, 32'h0, 1'b0);
  endtask

  task automatic test_widths();
    write_width(9'd0);
    send_word(8'd0, 8'd9, 32'h1, 32'h2, 32'h3, 1'b1);
    send_word(8'd255, 8'd0, 32'h1, 32'h2, 32'h3, 1'b1);
    write_width(9'd1);
    send_word(8'd0, 8'd5, 32'h0002_0000, 32'h1, 32'h1, 1'b1);
    send_word(8'd1, 8'd5, 32'h0002_0000, 32'h1, 32'h1, 1'b1);
    send_word(8'd0, 8'd5, 32'h0004_0000, 32'h3, 32'h5, 1'b1);
    write_width(9'd511);
    send_word(8'd255, 8'd255, 32'h0005_0000, 32'h1, 32'h1, 1'b1);
    send_word(8'd200, 8'd130, 32'h0006_0000, 32'h1, 32'h1, 1'b1);
  endtask

  task automatic random_phase(int n_items);
    logic [7:0] px, py;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) == 0) begin
        px = $urandom;
        py = $urandom;
      end else begin
        px = $urandom_range(3);
        py = $urandom_range(3);
      end
      send_word(px, py, rand_sample(), rand_sample(), rand_sample(),
                $urandom_range(99) >= 15);
    end
  endtask

  task automatic test_random();
    write_width(9'd256);
    random_phase(400);
    write_width(9'd3);
    random_phase(300);
    write_width(9'($urandom_range(511)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(300);
    tx_idle_pct = 32;
    rx_idle_pct = 32;
    write_width(9'd256);
    random_phase(400);
  endtask

  task automatic test_backpressure();
    rx_hold = 3000;
    tx_idle_pct = 0;
    random_phase(40);
    tx_idle_pct = 32;
    drain();
    random_phase(60);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_extremes();
    test_widths();
    test_random();
    test_backpressure();
    drain();
    if (fail_cnt == 0 && stats_q.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end
endmodule
